[hw/rtl/gbr_pkg.sv]
// Shared types and constants for the gap burstiness ratio unit.
// No dependencies; used by gbr_dp, gbr_ctrl and the top level.
`default_nettype none

package gbr_pkg;

    // Field widths
    localparam int TS_W    = 40;  // timestamp in microseconds
    localparam int WIN_W   = 27;  // window register in milliseconds
    localparam int WUS_W   = 37;  // window in microseconds
    localparam int RATIO_W = 17;  // Q1.16 ratio
    localparam int FRAC_W  = 16;  // fraction bits of the ratio
    localparam int STEP_W  = 5;   // holds FRAC_W, the first divider step

    // Window scaling and reset value
    localparam int US_PER_MS  = 1000;
    localparam int WIN_RESET  = 3000;

    // Minimum counts for a valid result
    localparam int MIN_GAPS = 3;
    localparam int REC_CAP  = 3;

    // Input record
    typedef struct packed {
        logic [TS_W-1:0] timestamp_us;
        logic            is_trade;
        logic            last;
    } t_in;

    // Result item
    typedef struct packed {
        logic [RATIO_W-1:0] burstiness;
        logic               valid_res;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // record transfer accepted
        logic scan_init;  // start window scan from newest trade
        logic scan_eval;  // check one trade, accumulate gap sum
        logic dev_init;   // restart walk for deviation pass
        logic dev_eval;   // read one trade, form gap
        logic dev_mul;    // n * gap
        logic dev_acc;    // accumulate |n*gap - S|
        logic div_init;   // form n*S, load divider
        logic div_step;   // one quotient bit
        logic fin;        // load result, clear set state
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_end;   // all stored trades visited
        logic in_window;  // current trade inside the window
        logic dev_first;  // first read of deviation pass
        logic dev_end;    // all kept trades read again
        logic div_last;   // final quotient bit this cycle
        logic go;         // enough data and nonzero gap sum
    } t_sts;

endpackage

`default_nettype wire

[hw/rtl/gbr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gbr_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4097
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/gbr_dp.sv]
// Datapath: trade ring, window scan, gap sums, deviation sum and ratio divider.
// Depends on gbr_pkg and gbr_ram; driven by commands from gbr_ctrl.
`default_nettype none

module gbr_dp #(
    parameter int MAX_GAPS = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire gbr_pkg::t_cmd             i_cmd,
    output gbr_pkg::t_sts                  o_sts,
    input  wire gbr_pkg::t_in              i_in_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [gbr_pkg::WIN_W-1:0] i_cfg_wdata,
    output gbr_pkg::t_out                  o_out_data
);

    localparam int DEPTH   = MAX_GAPS + 1;
    localparam int AW      = $clog2(DEPTH);
    localparam int PW      = $clog2(DEPTH + 1);
    localparam int CW      = $clog2(MAX_GAPS + 1);
    localparam int TS_W    = gbr_pkg::TS_W;
    localparam int WUS_W   = gbr_pkg::WUS_W;
    localparam int RATIO_W = gbr_pkg::RATIO_W;
    localparam int FRAC_W  = gbr_pkg::FRAC_W;
    localparam int STEP_W  = gbr_pkg::STEP_W;
    localparam int SW      = TS_W + CW;       // gap sum, n * gap
    localparam int VW      = TS_W + 2 * CW;   // deviation sum, n * S
    localparam int RW      = VW + FRAC_W;     // divider width

    // Set state and window
    logic [WUS_W-1:0] r_win_us;
    logic [AW-1:0]    r_wptr;
    logic [PW-1:0]    r_cnt;
    logic [1:0]       r_rec;
    logic [TS_W-1:0]  r_newest;

    // Walk and arithmetic state
    logic [AW-1:0]      r_rptr;
    logic [PW-1:0]      r_k;
    logic [PW-1:0]      r_j;
    logic [TS_W-1:0]    r_prev;
    logic [SW-1:0]      r_sum;
    logic [TS_W-1:0]    r_gap;
    logic [SW-1:0]      r_ng;
    logic [VW-1:0]      r_dev;
    logic [RW-1:0]      r_rem;
    logic [RW-1:0]      r_ds;
    logic [RATIO_W-1:0] r_q;
    logic [STEP_W-1:0]  r_step;
    gbr_pkg::t_out      r_out;

    logic [TS_W-1:0] w_rdata;
    logic [AW-1:0]   w_start_ptr;
    logic [AW-1:0]   w_rptr_dec;
    logic [AW-1:0]   w_wptr_inc;
    logic [TS_W-1:0] w_absdiff;
    logic            w_older;
    logic [CW-1:0]   w_n;
    logic            w_ok;
    logic [SW-1:0]   w_dev_term;
    logic            w_ge;

    // Trade ring
    gbr_ram #(
        .WIDTH (TS_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load & i_in_data.is_trade),
        .i_waddr (r_wptr),
        .i_wdata (i_in_data.timestamp_us),
        .i_raddr (r_rptr),
        .o_rdata (w_rdata)
    );

    // Ring pointer arithmetic with wrap at DEPTH
    always_comb begin
        w_start_ptr = (r_wptr == '0) ? AW'(DEPTH - 1) : r_wptr - AW'(1);
        w_rptr_dec  = (r_rptr == '0) ? AW'(DEPTH - 1) : r_rptr - AW'(1);
        w_wptr_inc  = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
    end

    // Window test and gap between successive trades
    always_comb begin
        w_older   = (r_newest > w_rdata) &&
                    ((r_newest - w_rdata) > TS_W'(r_win_us));
        w_absdiff = (r_prev > w_rdata) ? r_prev - w_rdata : w_rdata - r_prev;
    end

    // Gap count and result qualification
    always_comb begin
        w_n  = CW'(r_k - PW'(1));
        w_ok = (r_rec == 2'(gbr_pkg::REC_CAP)) && (r_k >= PW'(gbr_pkg::MIN_GAPS + 1));
        w_dev_term = (r_ng > r_sum) ? r_ng - r_sum : r_sum - r_ng;
        w_ge = (r_rem >= r_ds);
    end

    // Status to controller
    always_comb begin
        o_sts.scan_end  = (r_k == r_cnt);
        o_sts.in_window = ~w_older;
        o_sts.dev_first = (r_j == '0);
        o_sts.dev_end   = (r_j == r_k);
        o_sts.div_last  = (r_step == '0);
        o_sts.go        = w_ok && (r_sum != '0);
    end

    // Window register, stored as microseconds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_us <= WUS_W'(gbr_pkg::WIN_RESET * gbr_pkg::US_PER_MS);
        end else if (i_cfg_we) begin
            r_win_us <= WUS_W'(i_cfg_wdata) * WUS_W'(gbr_pkg::US_PER_MS);
        end
    end

    // Set bookkeeping: record transfers fill it, the result clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_cnt    <= '0;
            r_rec    <= '0;
            r_newest <= '0;
        end else if (i_cmd.fin) begin
            r_wptr <= '0;
            r_cnt  <= '0;
            r_rec  <= '0;
        end else if (i_cmd.load) begin
            r_newest <= i_in_data.timestamp_us;
            if (r_rec != 2'(gbr_pkg::REC_CAP)) begin
                r_rec <= r_rec + 2'd1;
            end
            if (i_in_data.is_trade) begin
                r_wptr <= w_wptr_inc;
                if (r_cnt != PW'(DEPTH)) begin
                    r_cnt <= r_cnt + PW'(1);
                end
            end
        end
    end

    // Walk: window scan with gap sum, then deviation pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_rptr <= w_start_ptr;
            r_k    <= '0;
            r_sum  <= '0;
        end
        if (i_cmd.scan_eval && !w_older) begin
            if (r_k != '0) begin
                r_sum <= r_sum + SW'(w_absdiff);
            end
            r_prev <= w_rdata;
            r_k    <= r_k + PW'(1);
            r_rptr <= w_rptr_dec;
        end
        if (i_cmd.dev_init) begin
            r_rptr <= w_start_ptr;
            r_j    <= '0;
            r_dev  <= '0;
        end
        if (i_cmd.dev_eval) begin
            r_gap  <= w_absdiff;
            r_prev <= w_rdata;
            r_j    <= r_j + PW'(1);
            r_rptr <= w_rptr_dec;
        end
        if (i_cmd.dev_mul) begin
            r_ng <= SW'(w_n) * SW'(r_gap);
        end
        if (i_cmd.dev_acc) begin
            r_dev <= r_dev + VW'(w_dev_term);
        end
    end

    // Restoring divider: (dev << 16) / (n * S), one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_ds   <= {VW'(w_n) * VW'(r_sum), FRAC_W'(0)};
            r_rem  <= {r_dev, FRAC_W'(0)};
            r_q    <= '0;
            r_step <= STEP_W'(FRAC_W);
        end else if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_ds;
            end
            r_q    <= {r_q[RATIO_W-2:0], w_ge};
            r_ds   <= r_ds >> 1;
            r_step <= r_step - STEP_W'(1);
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out.burstiness <= o_sts.go ? r_q : '0;
            r_out.valid_res  <= w_ok;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

[hw/rtl/gbr_ctrl.sv]
// Controller: sequences record loading, window scan, deviation pass, divide and result.
// Depends on gbr_pkg; commands gbr_dp.
`default_nettype none

module gbr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output gbr_pkg::t_cmd      o_cmd,
    input  wire gbr_pkg::t_sts i_sts
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SCAN_INIT = 4'd1;
    localparam logic [3:0] ST_SCAN_RD   = 4'd2;
    localparam logic [3:0] ST_SCAN_EV   = 4'd3;
    localparam logic [3:0] ST_CHK       = 4'd4;
    localparam logic [3:0] ST_DEV_RD    = 4'd5;
    localparam logic [3:0] ST_DEV_EV    = 4'd6;
    localparam logic [3:0] ST_DEV_MUL   = 4'd7;
    localparam logic [3:0] ST_DEV_ACC   = 4'd8;
    localparam logic [3:0] ST_DIV_INIT  = 4'd9;
    localparam logic [3:0] ST_DIV       = 4'd10;
    localparam logic [3:0] ST_FIN       = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;
    logic       w_accept;
    logic       w_slot_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_slot_free = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept && i_in_last) begin
                    n_state = ST_SCAN_INIT;
                end
            end
            ST_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state = ST_SCAN_RD;
            end
            // read data for r_rptr arrives next cycle
            ST_SCAN_RD: begin
                n_state = i_sts.scan_end ? ST_CHK : ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                o_cmd.scan_eval = 1'b1;
                n_state = i_sts.in_window ? ST_SCAN_RD : ST_CHK;
            end
            ST_CHK: begin
                o_cmd.dev_init = 1'b1;
                n_state = i_sts.go ? ST_DEV_RD : ST_FIN;
            end
            ST_DEV_RD: begin
                n_state = i_sts.dev_end ? ST_DIV_INIT : ST_DEV_EV;
            end
            ST_DEV_EV: begin
                o_cmd.dev_eval = 1'b1;
                n_state = i_sts.dev_first ? ST_DEV_RD : ST_DEV_MUL;
            end
            ST_DEV_MUL: begin
                o_cmd.dev_mul = 1'b1;
                n_state = ST_DEV_ACC;
            end
            ST_DEV_ACC: begin
                o_cmd.dev_acc = 1'b1;
                n_state = ST_DEV_RD;
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            // wait for the output register to free up
            ST_FIN: begin
                if (w_slot_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on result load, cleared on transfer
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.fin) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gap_burstiness_ratio_unit.sv]
// Top level of the gap burstiness ratio unit: controller plus datapath.
// Depends on gbr_pkg, gbr_ctrl, gbr_dp (and gbr_ram through gbr_dp).
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_stall    i_in_data  (t_in)
//   out       output     o_out_valid / i_out_stall  o_out_data (t_out)
//   cfg       input      i_cfg_we                   i_cfg_wdata (window_ms)
//
// Records load at one per cycle while idle (o_in_stall low); a record marked last starts
// the set computation: a window scan over the stored trades, a deviation pass over the
// kept gaps (single RAM read port, registered read), then the bitwise divider; a set
// with too few records or gaps or a zero gap sum skips the deviation pass and divider.
// o_in_stall is high from the cycle after a last record until its result is loaded
// into the output register; a stalled output only delays that load.
// Synchronous active-low reset; the trade ring itself is not cleared.
`default_nettype none

module gap_burstiness_ratio_unit #(
    parameter int MAX_GAPS = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire gbr_pkg::t_in              i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output gbr_pkg::t_out                  o_out_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [gbr_pkg::WIN_W-1:0] i_cfg_wdata
);

    gbr_pkg::t_cmd w_cmd;
    gbr_pkg::t_sts w_sts;

    // Sequencer
    gbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Ring, sums and divider
    gbr_dp #(
        .MAX_GAPS (MAX_GAPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
